@@ src/m3ws_pkg.sv @@
`timescale 1ns / 1ps

package m3ws_pkg;

	localparam int SAMPLE_W         = 20;
	localparam int SUM_W            = 26;
	localparam int COUNT_W          = 6;
	localparam int MEDIAN_TAPS      = 3;
	localparam int WINDOW_DEPTH_DEF = 48;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(21);

	// window stage status towards the top level
	typedef struct packed {
		logic                ok;     // prefetched oldest entry lines up, item may enter
		logic [SUM_W-1:0]    sum;    // total after the present request
		logic                full;   // wrapped flag after the present request
	} win_res_t;

	// middle value of three
	function automatic logic [SAMPLE_W-1:0] mid3(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c
	);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) begin
			return lo;
		end else if (c >= hi) begin
			return hi;
		end
		return c;
	endfunction

endpackage

@@ src/m3ws_median.sv @@
`timescale 1ns / 1ps

module m3ws_median
	import m3ws_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [SAMPLE_W-1:0] sample,
	output logic [SAMPLE_W-1:0] filt
);

	logic [SAMPLE_W-1:0] ring_q [MEDIAN_TAPS];
	logic [1:0]          pos_q;
	logic                primed_q;

	logic [1:0]          pos_eff;
	logic [1:0]          pos_nxt;
	logic                primed_nxt;
	logic [SAMPLE_W-1:0] ring_nxt [MEDIAN_TAPS];

	always_comb begin
		pos_eff    = (pos_q == 2'(MEDIAN_TAPS)) ? 2'd0 : pos_q;
		primed_nxt = primed_q;
		if (pos_eff == 2'(MEDIAN_TAPS - 1)) begin
			pos_nxt    = 2'd0;
			primed_nxt = 1'b1;
		end else begin
			pos_nxt = pos_eff + 2'd1;
		end
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			ring_nxt[i] = (pos_eff == 2'(i)) ? sample : ring_q[i];
		end
		filt = primed_nxt ? mid3(ring_nxt[0], ring_nxt[1], ring_nxt[2]) : sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEDIAN_TAPS; i++) ring_q[i] <= '0;
			pos_q    <= 2'd0;
			primed_q <= 1'b0;
		end else if (adv) begin
			ring_q   <= ring_nxt;
			pos_q    <= pos_nxt;
			primed_q <= primed_nxt;
		end
	end

endmodule

@@ src/m3ws_window.sv @@
`timescale 1ns / 1ps

module m3ws_window
	import m3ws_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [SAMPLE_W-1:0] filt,
	input  logic [COUNT_W-1:0]  window_count,
	output win_res_t            res
);

	localparam int PW = $clog2(WINDOW_DEPTH);
	localparam int XW = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;

	// {wrap, next index}
	function automatic logic [PW:0] step_idx(
		input logic [PW-1:0] p,
		input logic [XW-1:0] cnt
	);
		logic [XW-1:0] s;
		s = XW'(p) + XW'(1);
		if (s >= cnt) begin
			return {1'b1, PW'(0)};
		end
		return {1'b0, s[PW-1:0]};
	endfunction

	logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] vld_q;

	logic [PW-1:0]       pos_q;
	logic [SUM_W-1:0]    total_q;
	logic                wrapped_q;

	// prefetch of the entry that the next request subtracts
	logic [PW-1:0]       rd_addr_q;
	logic [SAMPLE_W-1:0] rd_mem_q;
	logic                rd_vld_q;
	logic                rd_byp_q;
	logic [SAMPLE_W-1:0] rd_bypd_q;

	logic [XW-1:0]       cnt_eff;
	logic [PW:0]         step_cur;
	logic [PW-1:0]       nxt_cur;
	logic [PW-1:0]       pos_next;
	logic [PW:0]         step_pre;
	logic [PW-1:0]       rd_addr;
	logic [SAMPLE_W-1:0] rd_val;
	logic [SAMPLE_W-1:0] oldest;

	always_comb begin
		cnt_eff  = (XW'(window_count) < XW'(WINDOW_DEPTH)) ? XW'(window_count)
		                                                   : XW'(WINDOW_DEPTH);
		step_cur = step_idx(pos_q, cnt_eff);
		nxt_cur  = step_cur[PW-1:0];
		pos_next = adv ? nxt_cur : pos_q;
		step_pre = step_idx(pos_next, cnt_eff);
		rd_addr  = step_pre[PW-1:0];

		if (rd_byp_q) begin
			rd_val = rd_bypd_q;
		end else if (rd_vld_q) begin
			rd_val = rd_mem_q;
		end else begin
			rd_val = '0;
		end
		// ring of one: the fresh entry is its own oldest
		oldest = (nxt_cur == pos_q) ? filt : rd_val;

		res.ok   = (rd_addr_q == nxt_cur) || (nxt_cur == pos_q);
		res.sum  = total_q + SUM_W'(filt) - SUM_W'(oldest);
		res.full = wrapped_q | step_cur[PW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mem[pos_q] <= filt;
		end
		rd_mem_q  <= mem[rd_addr];
		rd_bypd_q <= filt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			pos_q     <= '0;
			total_q   <= '0;
			wrapped_q <= 1'b0;
			rd_addr_q <= '0;
			rd_vld_q  <= 1'b0;
			rd_byp_q  <= 1'b0;
		end else begin
			rd_addr_q <= rd_addr;
			rd_vld_q  <= vld_q[rd_addr];
			rd_byp_q  <= adv && (rd_addr == pos_q);
			if (adv) begin
				vld_q[pos_q] <= 1'b1;
				pos_q        <= nxt_cur;
				total_q      <= res.sum;
				wrapped_q    <= res.full;
			end
		end
	end

endmodule

@@ src/median3_moving_window_sum.sv @@
`timescale 1ns / 1ps

// Median-of-three filter over raw pressure samples, followed by a moving-window
// sum of the filtered samples. Each request on the input channel gives exactly
// one request on the output channel carrying the running sum, the filtered
// sample and the window_full flag, held in an output register. A fresh request
// enters every cycle while that register is free and the window prefetch lines
// up. The entry to be subtracted is prefetched from the ring memory into a
// register, so after reset, and after a window_count write that moves the
// prefetch, the input stalls while it is re-aimed. The median taps are reset
// directly; the window ring reads as zero after reset through per-entry valid
// bits, so there is no clearing pass. window_count is taken as
// min(window_count, WINDOW_DEPTH); the sum spans that figure minus one
// samples and wraps modulo 2^26. Write window_count only while idle.

module median3_moving_window_sum
	import m3ws_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] pressure_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SUM_W-1:0]    window_sum,
	output logic [SAMPLE_W-1:0] filtered_sample,
	output logic                window_full
);

	logic [COUNT_W-1:0]  window_count_q;
	logic                out_valid_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] filt_q;
	logic                full_q;

	logic                adv;
	logic [SAMPLE_W-1:0] filt;
	win_res_t            win;

	// output register frees up when empty or being drained this cycle
	assign in_ready = (!out_valid_q || out_ready) && win.ok;
	assign adv      = in_valid && in_ready;

	m3ws_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.sample (pressure_sample),
		.filt   (filt)
	);

	m3ws_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.filt         (filt),
		.window_count (window_count_q),
		.res          (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			window_count_q <= cfg_wdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				full_q      <= win.full;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_q  <= win.sum;
			filt_q <= filt;
		end
	end

	assign out_valid       = out_valid_q;
	assign window_sum      = sum_q;
	assign filtered_sample = filt_q;
	assign window_full     = full_q;

endmodule

@@ src/m3ws_checker.sv @@
`timescale 1ns / 1ps

module m3ws_checker
	import m3ws_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SUM_W-1:0]    window_sum,
	input logic [SAMPLE_W-1:0] filtered_sample,
	input logic                window_full
);

	// a held result blocks new requests
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// every accepted request shows up on the output next cycle
	a_one_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result missing after accepted request");

	// wrapped flag is sticky
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		window_full |=> window_full)
		else $error("window_full dropped");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_sum)
		&& $stable(filtered_sample))
		else $error("stalled result changed");

endmodule

bind median3_moving_window_sum m3ws_checker u_m3ws_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.window_sum      (window_sum),
	.filtered_sample (filtered_sample),
	.window_full     (window_full)
);

@@ sim/tb_median3_moving_window_sum.sv @@
`timescale 1ns / 1ps

module tb_median3_moving_window_sum
	import m3ws_pkg::*;
();

	localparam int                  DEPTH      = WINDOW_DEPTH_DEF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	// one output request as the block should present it
	typedef struct {
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] filt;
		logic                full;
	} filter_sum_t;

	// how the random samples of one phase are shaped
	typedef enum int {
		SPREAD,     // anywhere in the 20-bit range
		NEAR_TOP,   // hugging full scale, pushes the total up
		NEAR_ZERO,  // small readings
		DRIFT       // slow wander round sea level with the odd outlier for the median
	} sample_shape_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                cfg_we          = 1'b0;
	logic [COUNT_W-1:0]  cfg_wdata       = '0;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] pressure_sample = '0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	logic [SUM_W-1:0]    window_sum;
	logic [SAMPLE_W-1:0] filtered_sample;
	logic                window_full;

	// input request taken at the last rising edge
	logic in_acc = 1'b0;

	logic [SAMPLE_W-1:0] pending_samples [$];
	filter_sum_t         due_sums [$];

	// shadow of the filter state, advanced once per accepted sample
	logic [COUNT_W-1:0]  model_count = COUNT_RESET;
	logic [SAMPLE_W-1:0] taps [MEDIAN_TAPS];
	int unsigned         tap_idx     = 0;
	bit                  taps_full   = 1'b0;
	logic [SAMPLE_W-1:0] win_mem [DEPTH];
	int unsigned         win_idx     = 0;
	logic [SUM_W-1:0]    win_total   = '0;
	bit                  win_wrapped = 1'b0;

	// gap control; idle_on off gives back-to-back stretches on both sides
	bit          idle_on        = 1'b0;
	int unsigned in_gap_left    = 0;
	int unsigned out_stall_left = 0;

	int unsigned mismatches   = 0;
	int unsigned samples_sent = 0;
	int unsigned results_seen = 0;
	int unsigned full_seen    = 0;
	int unsigned count_loads  = 0;
	int unsigned count_lo     = 63;
	int unsigned count_hi     = 0;

	median3_moving_window_sum i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pressure_sample (pressure_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.window_sum      (window_sum),
		.filtered_sample (filtered_sample),
		.window_full     (window_full)
	);

	always #5 clk = ~clk;

	// Median of three (raw sample until three are in), then the moving sum.
	// The total adds the new entry and drops the one after it in the ring, so
	// it spans count minus one entries; count 0 or 1 drops the entry just
	// written and the total holds still.
	function automatic filter_sum_t filter_and_accumulate(input logic [SAMPLE_W-1:0] sample);
		filter_sum_t         r;
		int unsigned         eff;
		int unsigned         cur;
		int unsigned         nxt;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] filt;
		eff = (model_count < DEPTH) ? model_count : DEPTH;
		cur = (win_idx < DEPTH) ? win_idx : 0;
		nxt = cur + 1;
		// wrap on reaching or passing the count, which also covers a count
		// lowered beneath the present position
		if (nxt >= eff) begin
			nxt         = 0;
			win_wrapped = 1'b1;
		end
		taps[tap_idx] = sample;
		tap_idx       = (tap_idx + 1) % MEDIAN_TAPS;
		if (tap_idx == 0) begin
			taps_full = 1'b1;
		end
		if (taps_full) begin
			lo   = (taps[0] < taps[1]) ? taps[0] : taps[1];
			hi   = (taps[0] < taps[1]) ? taps[1] : taps[0];
			filt = (taps[2] < lo) ? lo : (taps[2] > hi) ? hi : taps[2];
		end else begin
			filt = sample;
		end
		win_mem[cur] = filt;
		// modulo 2^26 through the assignment width
		win_total = win_total + SUM_W'(filt) - SUM_W'(win_mem[nxt]);
		win_idx   = nxt;
		r.sum  = win_total;
		r.filt = filt;
		r.full = win_wrapped;
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// sample driver: valid holds with its payload until the request is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_acc) begin
			if (in_gap_left > 0) begin
				in_valid <= 1'b0;
				in_gap_left--;
			end else if (pending_samples.size() > 0) begin
				in_valid        <= 1'b1;
				pressure_sample <= pending_samples.pop_front();
				in_gap_left      = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_stall_left > 0) begin
			out_ready <= 1'b0;
			out_stall_left--;
		end else begin
			out_ready      <= 1'b1;
			out_stall_left  = pick_gap();
		end
	end

	// both handshakes are observed here; results are checked before the
	// sample of the same edge is predicted
	always @(posedge clk) begin
		filter_sum_t want;
		in_acc <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (window_full === 1'b1) begin
				full_seen++;
			end
			if (due_sums.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual sum %0d filt %0d full %0b",
					$time, window_sum, filtered_sample, window_full);
			end else begin
				want = due_sums.pop_front();
				if (window_sum !== want.sum) begin
					mismatches++;
					$display("%0t: window_sum expected %0d actual %0d",
						$time, want.sum, window_sum);
				end
				if (filtered_sample !== want.filt) begin
					mismatches++;
					$display("%0t: filtered_sample expected %0d actual %0d",
						$time, want.filt, filtered_sample);
				end
				if (window_full !== want.full) begin
					mismatches++;
					$display("%0t: window_full expected %0b actual %0b",
						$time, want.full, window_full);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			samples_sent++;
			due_sums.push_back(filter_and_accumulate(pressure_sample));
		end
	end

	// nothing queued, nothing on the input wire, nothing awaited
	task automatic wait_drained();
		while (pending_samples.size() != 0 || due_sums.size() != 0 || in_valid) begin
			@(posedge clk);
		end
	endtask

	// register write only once the block has gone quiet
	task automatic load_window_count(input logic [COUNT_W-1:0] value);
		wait_drained();
		repeat (3) @(negedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= value;
		model_count  = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		count_loads++;
		if (value < count_lo) begin
			count_lo = value;
		end
		if (value > count_hi) begin
			count_hi = value;
		end
	endtask

	initial begin
		logic [SAMPLE_W-1:0] opening [10];
		logic [COUNT_W-1:0]  corner_counts [6];
		logic [COUNT_W-1:0]  cnt;
		logic [SAMPLE_W-1:0] s;
		sample_shape_t       shape;
		int unsigned         level;
		int unsigned         step;
		int unsigned         n;
		int unsigned         random_items;

		opening = '{20'h00000, 20'hFFFFF, 20'h12345, 20'hFFFFF,
			20'h00000, 20'hAAAAA, 20'h55555, 20'hFFFFF, 20'hFFFFF, 20'h00001};
		corner_counts = '{6'd0, 6'd1, 6'd2, 6'd48, 6'd49, 6'd63};

		foreach (taps[i]) begin
			taps[i] = '0;
		end
		foreach (win_mem[i]) begin
			win_mem[i] = '0;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset count: the first two pass raw, then
		// the median takes over; full-scale and alternating bit patterns
		foreach (opening[i]) begin
			pending_samples.push_back(opening[i]);
		end

		// shortest useful window, with the position well past it
		load_window_count(6'd2);
		pending_samples.push_back(20'hFFFFF);
		pending_samples.push_back(20'h00000);
		pending_samples.push_back(20'h80000);
		pending_samples.push_back(20'h7FFFF);

		// count of zero and of one: total frozen, flag set at once
		load_window_count(6'd0);
		pending_samples.push_back(20'hFFFFF);
		pending_samples.push_back(20'hFFFFF);
		pending_samples.push_back(20'h00003);
		load_window_count(6'd1);
		pending_samples.push_back(20'h00000);
		pending_samples.push_back(20'hFFFFF);

		// all register bits high, clipped to the ring depth
		load_window_count(6'd63);
		pending_samples.push_back(20'h40000);
		pending_samples.push_back(20'h3FFFF);
		pending_samples.push_back(20'hC0000);

		load_window_count(6'd48);
		pending_samples.push_back(20'hFFFFF);
		pending_samples.push_back(20'h00001);
		pending_samples.push_back(20'hFFFFF);

		// random phases, each under a fresh count and shape
		random_items = 0;
		level        = 101325;
		while (random_items < 350) begin
			if ($urandom_range(0, 99) < 20) begin
				cnt = corner_counts[$urandom_range(0, 5)];
			end else begin
				cnt = COUNT_W'($urandom_range(2, DEPTH));
			end
			load_window_count(cnt);
			idle_on = ($urandom_range(0, 3) != 0);
			shape   = sample_shape_t'($urandom_range(0, 3));
			n       = $urandom_range(15, 50);
			repeat (n) begin
				case (shape)
					SPREAD: begin
						s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
					end
					NEAR_TOP: begin
						s = SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 255));
					end
					NEAR_ZERO: begin
						s = SAMPLE_W'($urandom_range(0, 255));
					end
					default: begin
						step  = $urandom_range(0, 64);
						level = $urandom_range(0, 1) ? level + step : level - step;
						if ($urandom_range(0, 9) == 0) begin
							s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
						end else begin
							s = SAMPLE_W'(level);
						end
					end
				endcase
				pending_samples.push_back(s);
			end
			random_items += n;
		end

		wait_drained();
		repeat (5) @(posedge clk);
		if (due_sums.size() != 0) begin
			mismatches += due_sums.size();
			$display("%0t: %0d results never arrived", $time, due_sums.size());
		end

		$display("Run: %0d samples in, %0d results checked, %0d carried the window-full flag.",
			samples_sent, results_seen, full_seen);
		$display("Window count loaded %0d times, between %0d and %0d.",
			count_loads, count_lo, count_hi);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog, far beyond the slowest run with every gap at its longest
	initial begin
		#5_000_000;
		$display("%0t: watchdog expired, %0d results still awaited", $time, due_sums.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
